### hdl/rita_pkg.sv
// shared types, constants and the digit-to-character mapping for the radix converter
// no dependencies; imported by every other module of the block
package rita_pkg;

  localparam int unsigned NUM_W    = 64;  // width of the value field
  localparam int unsigned BASE_W   = 7;   // width of the signed radix field
  localparam int unsigned CHAR_W   = 8;   // ascii character width
  localparam int unsigned MAG_W    = 6;   // holds any legal radix and any remainder
  localparam int unsigned CHAR_PAD = CHAR_W - MAG_W;

  localparam int unsigned Q_DEPTH = 2;    // entries in the front-to-back queue
  localparam int unsigned Q_AW    = 1;    // index bits for Q_DEPTH
  localparam int unsigned Q_CW    = 2;    // fill count bits, holds Q_DEPTH

  localparam logic [BASE_W-1:0] MIN_RADIX = 7'd2;
  localparam logic [BASE_W-1:0] MAX_RADIX = 7'd36;
  localparam logic [MAG_W-1:0]  DEC_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // one classified request on its way from the front to the back
  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic [MAG_W-1:0] mag;
    logic             upper;
    logic             bad;
  } entry_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [MAG_W-1:0] rem,
                                                      input logic upper);
    logic [CHAR_W-1:0] r8;
    logic [CHAR_W-1:0] letter;
    r8     = {{CHAR_PAD{1'b0}}, rem};
    letter = upper ? CHAR_UPPER : CHAR_LOWER;
    if (rem < DEC_RADIX) begin
      return CHAR_ZERO + r8;
    end else begin
      return letter + r8 - {{CHAR_PAD{1'b0}}, DEC_RADIX};
    end
  endfunction

endpackage

### hdl/rita_front.sv
// front stage: takes a request, splits the radix into magnitude and letter case,
// flags an illegal radix and hands the entry to the queue; uses rita_pkg
module rita_front #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [rita_pkg::NUM_W-1:0]            number_i,
  input  logic signed [rita_pkg::BASE_W-1:0]    base_sel_i,
  output logic                                  push_valid_o,
  input  logic                                  push_stall_i,
  output rita_pkg::entry_t                      push_entry_o
);
  import rita_pkg::*;

  logic             slot_valid_q, slot_valid_d;
  entry_t           slot_q;
  entry_t           cls;
  logic [BASE_W-1:0] base_u;
  logic [BASE_W-1:0] mag_full;
  logic             accept;
  logic             push;

  always_comb begin
    base_u    = base_sel_i;
    mag_full  = base_u[BASE_W-1] ? (BASE_W'(0) - base_u) : base_u;
    cls.value = NUM_W'(number_i[VALUE_BITS-1:0]);
    cls.mag   = mag_full[MAG_W-1:0];
    // zero counts as non-positive, so it picks upper case
    cls.upper = base_u[BASE_W-1] | (base_u == '0);
    cls.bad   = (mag_full < MIN_RADIX) | (mag_full > MAX_RADIX);
  end

  assign push         = slot_valid_q & ~push_stall_i;
  assign in_stall_o   = slot_valid_q & push_stall_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign slot_valid_d = accept | (slot_valid_q & ~push);
  assign push_valid_o = slot_valid_q;
  assign push_entry_o = slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= cls;
    end
  end

endmodule

### hdl/rita_queue.sv
// two-entry queue between the front and the back stage
// depends on rita_pkg for the entry type and depth constants
module rita_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  rita_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output rita_pkg::entry_t pop_entry_o
);
  import rita_pkg::*;

  entry_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] count_q;
  logic            push, pop;

  assign push_stall_o = (count_q == Q_CW'(Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i & ~push_stall_o;
  assign pop          = pop_valid_o & ~pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + Q_CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### hdl/rita_back.sv
// back stage: repeated division by the radix, digit stack, character output register
// depends on rita_pkg; digits are produced least significant first and popped in reverse
module rita_back #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_stall_o,
  input  rita_pkg::entry_t              pop_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rita_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o,
  output logic                          bad_radix_o
);
  import rita_pkg::*;

  localparam int unsigned STEP_BITS = 4;
  localparam int unsigned PAD_BITS  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned STEPS     = PAD_BITS / STEP_BITS;
  localparam int unsigned SW        = $clog2(STEPS);
  localparam int unsigned AW        = $clog2(VALUE_BITS);
  localparam int unsigned PW        = AW + 1;

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    READ,
    EMIT,
    BAD
  } state_e;

  state_e              state_q;
  logic [PAD_BITS-1:0] val_q, val_d;
  logic [MAG_W-1:0]    rem_q, rem_d;
  logic [MAG_W-1:0]    mag_q;
  logic                upper_q;
  logic [SW-1:0]       step_q;
  logic [PW-1:0]       sp_q, sp_dec;
  logic [MAG_W-1:0]    stack_q [VALUE_BITS];
  logic [MAG_W-1:0]    rdata_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q, out_bad_q;
  logic                out_free;
  logic                out_load;
  logic                last_step;
  logic                take;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_load    = out_free & ((state_q == EMIT) | (state_q == BAD));
  assign last_step   = (step_q == SW'(STEPS - 1));
  assign pop_stall_o = (state_q != IDLE);
  assign take        = pop_valid_i & (state_q == IDLE);
  assign sp_dec      = sp_q - PW'(1);

  // STEP_BITS restoring division steps per cycle on a narrow remainder
  always_comb begin
    logic [MAG_W:0]         r;
    logic [STEP_BITS-1:0]   qb;
    r  = {1'b0, rem_q};
    qb = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[MAG_W-1:0], val_q[PAD_BITS-1-i]};
      if (r >= {1'b0, mag_q}) begin
        r = r - {1'b0, mag_q};
        qb[STEP_BITS-1-i] = 1'b1;
      end
    end
    rem_d = r[MAG_W-1:0];
    val_d = {val_q[PAD_BITS-STEP_BITS-1:0], qb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      val_q       <= '0;
      rem_q       <= '0;
      mag_q       <= '0;
      upper_q     <= 1'b0;
      step_q      <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q & out_stall_i) | out_load;
      case (state_q)
        IDLE: begin
          if (take) begin
            val_q   <= PAD_BITS'(pop_entry_i.value[VALUE_BITS-1:0]);
            rem_q   <= '0;
            mag_q   <= pop_entry_i.mag;
            upper_q <= pop_entry_i.upper;
            step_q  <= '0;
            sp_q    <= '0;
            state_q <= pop_entry_i.bad ? BAD : DIVIDE;
          end
        end
        DIVIDE: begin
          if (last_step) begin
            // one digit done, quotient stays in val for the next digit
            val_q   <= val_d;
            rem_q   <= '0;
            step_q  <= '0;
            sp_q    <= sp_q + PW'(1);
            if (val_d == '0) begin
              state_q <= READ;
            end
          end else begin
            val_q  <= val_d;
            rem_q  <= rem_d;
            step_q <= step_q + SW'(1);
          end
        end
        READ: begin
          sp_q    <= sp_dec;
          state_q <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            out_char_q  <= digit_to_char(rdata_q, upper_q);
            out_last_q  <= (sp_q == '0);
            out_bad_q   <= 1'b0;
            state_q     <= (sp_q == '0) ? IDLE : READ;
          end
        end
        BAD: begin
          if (out_free) begin
            out_char_q  <= CHAR_NONE;
            out_last_q  <= 1'b1;
            out_bad_q   <= 1'b1;
            state_q     <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // digit stack
  always_ff @(posedge clk_i) begin
    if (state_q == DIVIDE && last_step) begin
      stack_q[sp_q[AW-1:0]] <= rem_d;
    end
    if (state_q == READ) begin
      rdata_q <= stack_q[sp_dec[AW-1:0]];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;
  assign bad_radix_o  = out_bad_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(VALUE_BITS))
    else $error("digit stack pointer beyond depth");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIVIDE) |-> (rem_q < mag_q))
    else $error("partial remainder not below radix");

  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_last_q && out_char_q == CHAR_NONE))
    else $error("bad radix result not a single empty last character");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IDLE) |-> (sp_q == '0))
    else $error("digit stack not empty between conversions");

endmodule

### hdl/radix_integer_to_ascii.sv
// radix_integer_to_ascii: turns an unsigned value into ascii digits in a radix of 2 to 36,
// one character per output request, most significant digit first, last flag on the final
// one. a positive base_sel_i gives letters a..z for digits ten and up, zero or negative
// gives A..Z. a radix magnitude outside 2 to 36 gives one request with bad_radix_o, last_o
// and character 0. a value of zero gives the single digit '0'. only the low VALUE_BITS
// bits of number_i count. the back stage divides by the radix four quotient bits per
// cycle, running through all the padded value bits for each digit, then each character
// comes off the digit stack by a memory read and then an output load, which waits out
// any output stall; a bad radix goes straight to the output load. the front stage and
// a two-entry queue keep accepting requests while the back stage works, so up to five
// requests can be in flight, counting one whose final character waits in the output
// register.
// depends on rita_pkg, rita_front, rita_queue and rita_back
module radix_integer_to_ascii #(
  parameter int unsigned VALUE_BITS = 64  // 8 to 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input requests
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rita_pkg::NUM_W-1:0]         number_i,
  input  logic signed [rita_pkg::BASE_W-1:0] base_sel_i,
  // output characters
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rita_pkg::CHAR_W-1:0]        digit_char_o,
  output logic                               last_o,
  output logic                               bad_radix_o
);
  import rita_pkg::*;

  // front to queue
  logic   f_valid, f_stall;
  entry_t f_entry;
  // queue to back
  logic   b_valid, b_stall;
  entry_t b_entry;

  // classify the radix and register the request
  rita_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_i     (number_i),
    .base_sel_i   (base_sel_i),
    .push_valid_o (f_valid),
    .push_stall_i (f_stall),
    .push_entry_o (f_entry)
  );

  // short decoupling queue
  rita_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_stall_o (f_stall),
    .push_entry_i (f_entry),
    .pop_valid_o  (b_valid),
    .pop_stall_i  (b_stall),
    .pop_entry_o  (b_entry)
  );

  // divide, stack digits, emit characters in reverse
  rita_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (b_valid),
    .pop_stall_o  (b_stall),
    .pop_entry_i  (b_entry),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o),
    .bad_radix_o  (bad_radix_o)
  );

endmodule
